/* rtl/quad_vertex_expander_top_assert.svh */
// Assertion macros for the quad vertex expander.
// Included by the top level; depends on nothing else.
`ifndef QUAD_VERTEX_EXPANDER_TOP_ASSERT_SVH
`define QUAD_VERTEX_EXPANDER_TOP_ASSERT_SVH
`define QVE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define QVE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/qve_pkg.sv */
// Shared types and constants of the quad vertex expander.
// Used by the controller, the datapath and the top level.
package qve_pkg;
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_DROP  = 2'd2;

    typedef struct packed {
        logic load;
        logic search;
        logic trig;
        logic mul;
        logic emit;
        logic [1:0] corner;
        logic [1:0] kind;
    } qve_cmd_t;

    typedef struct packed {
        logic search_done;
        logic drop;
    } qve_stat_t;

    function automatic logic [16:0] sin_entry(input logic [5:0] k);
        logic [16:0] r;
        case (k)
            6'd0: r = 17'd0;      6'd1: r = 17'd3216;   6'd2: r = 17'd6424;
            6'd3: r = 17'd9616;   6'd4: r = 17'd12785;  6'd5: r = 17'd15924;
            6'd6: r = 17'd19024;  6'd7: r = 17'd22078;  6'd8: r = 17'd25080;
            6'd9: r = 17'd28020;  6'd10: r = 17'd30893; 6'd11: r = 17'd33692;
            6'd12: r = 17'd36410; 6'd13: r = 17'd39040; 6'd14: r = 17'd41576;
            6'd15: r = 17'd44011; 6'd16: r = 17'd46341; 6'd17: r = 17'd48559;
            6'd18: r = 17'd50660; 6'd19: r = 17'd52639; 6'd20: r = 17'd54491;
            6'd21: r = 17'd56212; 6'd22: r = 17'd57798; 6'd23: r = 17'd59244;
            6'd24: r = 17'd60547; 6'd25: r = 17'd61705; 6'd26: r = 17'd62714;
            6'd27: r = 17'd63572; 6'd28: r = 17'd64277; 6'd29: r = 17'd64827;
            6'd30: r = 17'd65220; 6'd31: r = 17'd65457;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    // Signed sine in Q16 for a 16-bit angle, from the interpolated quarter wave.
    function automatic logic signed [17:0] fx_sin(input logic [15:0] a);
        logic [14:0] u;
        logic [5:0] i;
        logic [8:0] f;
        logic [16:0] t0;
        logic [16:0] t1;
        logic [26:0] p;
        logic [16:0] m;
        u = a[14] ? (15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        i = u[14:9];
        f = u[8:0];
        t0 = sin_entry(i);
        t1 = sin_entry(i + 6'd1);
        p = (t1 - t0) * f;
        m = (i >= 6'd32) ? 17'd65536 : t0 + p[25:9];
        return a[15] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction
endpackage

/* rtl/qve_ctrl.sv */
// Controller state machine of the quad vertex expander.
// Depends on qve_pkg; drives the datapath by command and status structs.
module qve_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [1:0]        in_op,
    input  logic              out_free,
    input  qve_pkg::qve_stat_t stat,
    output logic              in_ready,
    output qve_pkg::qve_cmd_t cmd
);
    import qve_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_TRIG = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [1:0] corner_reg, corner_next;
    logic [1:0] kind_reg, kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        corner_next = corner_reg;
        kind_next = kind_reg;
        cmd = '0;
        cmd.corner = corner_reg;
        cmd.kind = kind_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    kind_next = in_op;
                    corner_next = 2'd0;
                    if (in_op == OP_DRAW) state_next = S_SRCH;
                    else if (in_op == OP_END) state_next = S_EMIT;
                end
            end
            S_SRCH: begin
                cmd.search = 1'b1;
                if (stat.drop) state_next = S_EMIT;
                else if (stat.search_done) state_next = S_TRIG;
            end
            S_TRIG: begin
                cmd.trig = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit = 1'b1;
                    if (kind_reg != OP_DRAW || stat.drop || corner_reg == 2'd3) begin
                        state_next = S_IDLE;
                    end else begin
                        corner_next = corner_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            corner_reg <= '0;
            kind_reg <= '0;
        end else begin
            state_reg <= state_next;
            corner_reg <= corner_next;
            kind_reg <= kind_next;
        end
    end
endmodule

/* rtl/qve_dp.sv */
// Datapath of the quad vertex expander: slot table, counters, vertex math.
// Depends on qve_pkg; commanded by qve_ctrl.
module qve_dp #(
    parameter int SLOT_DEPTH = 32,
    parameter int MAX_QUADS = 16384
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  qve_pkg::qve_cmd_t cmd,
    output qve_pkg::qve_stat_t stat,
    input  logic [1:0]        in_op,
    input  logic [31:0]       in_pos_x,
    input  logic [31:0]       in_pos_y,
    input  logic [31:0]       in_pos_z,
    input  logic [31:0]       in_size_x,
    input  logic [31:0]       in_size_y,
    input  logic [15:0]       in_angle,
    input  logic [31:0]       in_rgba,
    input  logic              in_textured,
    input  logic [15:0]       in_texture_id,
    output logic [152:0]      res_data,
    output logic [7:0]        res_user,
    output logic [16:0]       slot_count_out
);
    import qve_pkg::*;

    localparam int SW = $clog2(SLOT_DEPTH);
    localparam int CW = $clog2(SLOT_DEPTH + 1);
    localparam int QW = $clog2(MAX_QUADS + 1);

    logic [15:0] slot_mem [SLOT_DEPTH];
    logic [15:0] rd_reg;
    logic [SW-1:0] idx_reg, idx_next;
    logic [CW-1:0] slot_count_reg;
    logic [QW-1:0] quad_count_reg;
    logic [SW-1:0] slot_reg;
    logic [1:0] status_reg;
    logic rd_valid_reg;
    logic drop_reg;
    logic found;

    logic signed [31:0] px_reg, py_reg, sx_reg, sy_reg;
    logic [31:0] pz_reg, rgba_reg;
    logic [15:0] angle_reg, tid_reg;
    logic tex_reg;
    logic signed [17:0] sin_reg, cos_reg;
    logic signed [49:0] p_cx_reg, p_sy_reg, p_sx_reg, p_cy_reg;
    logic signed [32:0] dx, dy;
    logic signed [63:0] xs, ys;
    logic [31:0] vx, vy;
    logic last;
    logic [16:0] icount;

    assign dx = (cmd.corner == 2'd0 || cmd.corner == 2'd3) ? -33'(sx_reg) : 33'(sx_reg);
    assign dy = (cmd.corner[1] == 1'b0) ? -33'(sy_reg) : 33'(sy_reg);
    assign xs = 64'(p_cx_reg) - 64'(p_sy_reg) + 64'sd65536;
    assign ys = 64'(p_sx_reg) + 64'(p_cy_reg) + 64'sd65536;
    assign vx = px_reg + xs[48:17];
    assign vy = py_reg + ys[48:17];

    // The table walk reads one entry per cycle; a hit ends it early.
    assign found = rd_valid_reg && (rd_reg == tid_reg);
    assign stat.drop = drop_reg;
    assign stat.search_done = !tex_reg || found ||
        (32'(idx_reg) + 32'd1 >= 32'(slot_count_reg));

    always_comb begin
        idx_next = idx_reg;
        if (cmd.search && !found) idx_next = idx_reg + SW'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg <= in_pos_x; py_reg <= in_pos_y; pz_reg <= in_pos_z;
            sx_reg <= in_size_x; sy_reg <= in_size_y; angle_reg <= in_angle;
            rgba_reg <= in_rgba; tex_reg <= in_textured; tid_reg <= in_texture_id;
        end
        if (cmd.search) rd_reg <= slot_mem[idx_next];
        if (cmd.trig) begin
            sin_reg <= fx_sin(angle_reg);
            cos_reg <= fx_sin(angle_reg + 16'd16384);
        end
        if (cmd.mul) begin
            p_cx_reg <= cos_reg * dx;
            p_sy_reg <= sin_reg * dy;
            p_sx_reg <= sin_reg * dx;
            p_cy_reg <= cos_reg * dy;
        end
        if (cmd.search && tex_reg && !found && stat.search_done && !drop_reg &&
                32'(slot_count_reg) < SLOT_DEPTH)
            slot_mem[slot_count_reg[SW-1:0]] <= tid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= CW'(1);
            quad_count_reg <= '0;
            rd_valid_reg <= 1'b0;
            drop_reg <= 1'b0;
            idx_reg <= '0;
            slot_reg <= '0;
            status_reg <= ST_OK;
        end else begin
            if (cmd.load) begin
                idx_reg <= '0;
                rd_valid_reg <= 1'b0;
                slot_reg <= '0;
                status_reg <= ST_OK;
                drop_reg <= (in_op == OP_DRAW) && (32'(quad_count_reg) >= MAX_QUADS);
                if (in_op == OP_BEGIN) begin
                    slot_count_reg <= CW'(1);
                    quad_count_reg <= '0;
                end
            end
            if (cmd.search && !drop_reg) begin
                idx_reg <= idx_next;
                rd_valid_reg <= 32'(idx_next) < 32'(slot_count_reg);
                if (stat.search_done) begin
                    quad_count_reg <= quad_count_reg + QW'(1);
                    if (found) slot_reg <= idx_reg;
                    else if (tex_reg) begin
                        if (32'(slot_count_reg) < SLOT_DEPTH) begin
                            slot_reg <= slot_count_reg[SW-1:0];
                            slot_count_reg <= slot_count_reg + CW'(1);
                        end else status_reg <= ST_FULL;
                    end
                end
            end
        end
    end

    assign icount = 17'(32'(quad_count_reg) * 6);
    assign slot_count_out = 17'(slot_count_reg);
    assign last = (cmd.kind != OP_DRAW) || drop_reg || cmd.corner == 2'd3;

    always_comb begin
        res_data = '0;
        res_user = '0;
        res_user[0] = last;
        res_user[2:1] = (cmd.kind == OP_DRAW && drop_reg) ? ST_DROP :
                        (cmd.kind == OP_DRAW ? status_reg : ST_OK);
        res_user[7:3] = 5'(slot_reg) & {5{cmd.kind == OP_DRAW && !drop_reg}};
        if (cmd.kind == OP_DRAW && !drop_reg) begin
            res_data[31:0] = vx;
            res_data[63:32] = vy;
            res_data[95:64] = pz_reg;
            res_data[127:96] = (tex_reg) ? 32'hFFFF_FFFF : rgba_reg;
            res_data[128] = (cmd.corner == 2'd1 || cmd.corner == 2'd2);
            res_data[129] = cmd.corner[1];
        end
        res_data[146:130] = icount;
        res_data[152:147] = 6'(slot_count_reg);
    end
endmodule

/* rtl/quad_vertex_expander_top.sv */
// Channel  | Dir | Transactions
// s_axis   | in  | one per scene, quad or ignored command
// m_axis   | out | four per drawn quad, one per end or dropped quad
// A drawn quad holds the input from accept until its last vertex is emitted:
// a search state over the slot entries, a sine state, then multiply and emit per vertex.
// An end scene emits directly, a dropped quad after search; begin or NOP only loads.
// The first vertex is loaded into the output register after the sine and multiply states.
// Reset is synchronous on aresetn; no clearing pass is needed.
// The output register stalls the machine only while a result waits unaccepted.
// Top level of the quad vertex expander; depends on qve_pkg, qve_ctrl, qve_dp.
module quad_vertex_expander_top #(
    parameter int SLOT_DEPTH = 32,
    parameter int MAX_QUADS = 16384
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, size_x, size_y, angle, rgba, textured, texture_id
    input  logic [231:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // vert_x, vert_y, vert_z, vert_color, tex_u, tex_v, index_count, slots_used
    output logic [159:0] m_tdata,
    // tex_slot, status
    output logic [6:0]   m_tuser,
    output logic         m_tlast
);
    import qve_pkg::*;
    `include "quad_vertex_expander_top_assert.svh"

    qve_cmd_t cmd;
    qve_stat_t stat;
    logic in_fire;
    logic out_free;
    logic [152:0] res_data;
    logic [7:0] res_user;
    logic [16:0] sc;
    logic [159:0] data_reg;
    logic [6:0] user_reg;
    logic last_reg, valid_reg;

    assign in_fire = s_tvalid && s_tready;
    assign out_free = !valid_reg || m_tready;

    qve_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_op(s_tuser),
        .out_free(out_free), .stat(stat), .in_ready(s_tready), .cmd(cmd)
    );

    qve_dp #(.SLOT_DEPTH(SLOT_DEPTH), .MAX_QUADS(MAX_QUADS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_op(s_tuser), .in_pos_x(s_tdata[31:0]), .in_pos_y(s_tdata[63:32]),
        .in_pos_z(s_tdata[95:64]), .in_size_x(s_tdata[127:96]),
        .in_size_y(s_tdata[159:128]), .in_angle(s_tdata[175:160]),
        .in_rgba(s_tdata[207:176]), .in_textured(s_tdata[208]),
        .in_texture_id(s_tdata[224:209]), .res_data(res_data),
        .res_user(res_user), .slot_count_out(sc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            data_reg <= {7'd0, res_data};
            user_reg <= {res_user[2:1], res_user[7:3]};
            last_reg <= res_user[0];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = data_reg;
    assign m_tuser = user_reg;
    assign m_tlast = last_reg;

    `QVE_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_tvalid, "emit lost")
    `QVE_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, cmd.emit, !s_tready, "busy accept")
    `QVE_ASSERT_IMPL(a_slots, aclk, aresetn, 1'b1, sc != 17'd0, "slot count zero")
endmodule
